/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General concurrent property with a message.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A stalled request keeps valid high and the watched payload unchanged.
`define CHK_STALL_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

/* rtl/yuvq_pkg.sv */
// Shared types and constants for the YUV 4:2:0 quad to packed pixel converter.
// No dependencies; used by every module of the block but the checker.
package yuvq_pkg;

	localparam int LANES     = 4;
	localparam int SAMPLE_W  = 8;
	localparam int PIXEL_W   = 32;
	localparam int TERM_W    = 18;
	localparam int ACC_W     = 19;
	localparam int APROD_W   = 25;
	localparam int RECIP_W   = 17;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// BT.601 integer matrix
	localparam logic signed [TERM_W-1:0] COEF_Y  = 18'sd298;
	localparam logic signed [TERM_W-1:0] COEF_RV = 18'sd409;
	localparam logic signed [TERM_W-1:0] COEF_GU = 18'sd100;
	localparam logic signed [TERM_W-1:0] COEF_GV = 18'sd208;
	localparam logic signed [TERM_W-1:0] COEF_BU = 18'sd516;
	localparam logic signed [TERM_W-1:0] ROUND_HALF = 18'sd128;
	localparam logic signed [TERM_W-1:0] LUMA_OFS   = 18'sd16;
	localparam logic signed [TERM_W-1:0] CHROMA_OFS = 18'sd128;

	// Alpha scale: 1/0.858823 in 1.16 fixed point
	localparam logic [RECIP_W-1:0]  ALPHA_RECIP = 17'd76309;
	localparam logic [SAMPLE_W-1:0] ALPHA_OFS   = 8'd16;
	localparam logic [SAMPLE_W-1:0] BYTE_MAX    = 8'hFF;

	// Register indexes (byte address bit 2)
	localparam logic REG_PASS_YUV_MODE = 1'b0;
	localparam logic REG_ALPHA_ENABLE  = 1'b1;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [PIXEL_W-1:0]  pixel_t;

	typedef struct packed {
		logic pass_yuv_mode;
		logic alpha_enable;
	} ctl_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] r_term;
		logic signed [TERM_W-1:0] g_term;
		logic signed [TERM_W-1:0] b_term;
		sample_t                  cb;
		sample_t                  cr;
	} chroma_t;

endpackage

/* rtl/yuvq_chroma.sv */
// Shared chroma terms of one quad: products of Cb and Cr with the matrix
// coefficients, rounding folded in, registered into stage 2. Uses yuvq_pkg.
module yuvq_chroma (
	input  logic              clk,
	input  logic              load_s2,
	input  yuvq_pkg::sample_t cb_s1,
	input  yuvq_pkg::sample_t cr_s1,
	output yuvq_pkg::chroma_t chroma_s2
);

	logic signed [yuvq_pkg::TERM_W-1:0] d_val;
	logic signed [yuvq_pkg::TERM_W-1:0] e_val;
	yuvq_pkg::chroma_t                  chroma_d;

	always_comb begin
		d_val = $signed({{(yuvq_pkg::TERM_W-yuvq_pkg::SAMPLE_W){1'b0}}, cb_s1})
			- yuvq_pkg::CHROMA_OFS;
		e_val = $signed({{(yuvq_pkg::TERM_W-yuvq_pkg::SAMPLE_W){1'b0}}, cr_s1})
			- yuvq_pkg::CHROMA_OFS;
		chroma_d.r_term = e_val * yuvq_pkg::COEF_RV + yuvq_pkg::ROUND_HALF;
		chroma_d.g_term = yuvq_pkg::ROUND_HALF - d_val * yuvq_pkg::COEF_GU
			- e_val * yuvq_pkg::COEF_GV;
		chroma_d.b_term = d_val * yuvq_pkg::COEF_BU + yuvq_pkg::ROUND_HALF;
		chroma_d.cb     = cb_s1;
		chroma_d.cr     = cr_s1;
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			chroma_s2 <= chroma_d;
		end
	end

endmodule

/* rtl/yuvq_lane.sv */
// One pixel lane: luma and alpha products in stage 2, then sum, clamp and
// pack into a 32-bit word. Uses yuvq_pkg; fed by yuvq_chroma.
module yuvq_lane (
	input  logic              clk,
	input  logic              load_s2,
	input  yuvq_pkg::sample_t luma_s1,
	input  yuvq_pkg::sample_t alpha_s1,
	input  yuvq_pkg::chroma_t chroma_s2,
	input  yuvq_pkg::ctl_t    ctl_s2,
	output yuvq_pkg::pixel_t  pixel
);

	logic signed [yuvq_pkg::TERM_W-1:0]  luma_c;
	logic signed [yuvq_pkg::TERM_W-1:0]  luma_term_s2;
	logic [yuvq_pkg::APROD_W-1:0]        alpha_prod;
	logic [yuvq_pkg::APROD_W-1:0]        alpha_prod_s2;
	yuvq_pkg::sample_t                   luma_s2;
	yuvq_pkg::sample_t                   red;
	yuvq_pkg::sample_t                   green;
	yuvq_pkg::sample_t                   blue;
	yuvq_pkg::sample_t                   alpha;
	logic [yuvq_pkg::APROD_W-17:0]       alpha_int;
	yuvq_pkg::pixel_t                    base_word;

	// Round already folded into the chroma term; floor, then clamp to a byte.
	function automatic yuvq_pkg::sample_t clamp_channel(
		input logic signed [yuvq_pkg::TERM_W-1:0] y_term,
		input logic signed [yuvq_pkg::TERM_W-1:0] c_term
	);
		logic signed [yuvq_pkg::ACC_W-1:0] acc;
		yuvq_pkg::sample_t                 res;
		acc = yuvq_pkg::ACC_W'(y_term) + yuvq_pkg::ACC_W'(c_term);
		if (acc[yuvq_pkg::ACC_W-1]) begin
			res = '0;
		end else if (|acc[yuvq_pkg::ACC_W-2:16]) begin
			res = yuvq_pkg::BYTE_MAX;
		end else begin
			res = acc[15:8];
		end
		return res;
	endfunction

	always_comb begin
		luma_c = $signed({{(yuvq_pkg::TERM_W-yuvq_pkg::SAMPLE_W){1'b0}}, luma_s1})
			- yuvq_pkg::LUMA_OFS;
		if (alpha_s1 < yuvq_pkg::ALPHA_OFS) begin
			alpha_prod = '0;
		end else begin
			alpha_prod = yuvq_pkg::APROD_W'(alpha_s1 - yuvq_pkg::ALPHA_OFS)
				* yuvq_pkg::APROD_W'(yuvq_pkg::ALPHA_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			luma_term_s2  <= luma_c * yuvq_pkg::COEF_Y;
			alpha_prod_s2 <= alpha_prod;
			luma_s2       <= luma_s1;
		end
	end

	always_comb begin
		red   = clamp_channel(luma_term_s2, chroma_s2.r_term);
		green = clamp_channel(luma_term_s2, chroma_s2.g_term);
		blue  = clamp_channel(luma_term_s2, chroma_s2.b_term);
		alpha_int = alpha_prod_s2[yuvq_pkg::APROD_W-1:16];
		alpha = (|alpha_int[yuvq_pkg::APROD_W-17:8]) ? yuvq_pkg::BYTE_MAX
			: alpha_int[7:0];
		if (ctl_s2.pass_yuv_mode) begin
			base_word = {yuvq_pkg::BYTE_MAX, luma_s2, chroma_s2.cb, chroma_s2.cr};
		end else begin
			base_word = {yuvq_pkg::BYTE_MAX, red, green, blue};
		end
		if (ctl_s2.alpha_enable) begin
			pixel = {alpha, base_word[23:0]};
		end else begin
			pixel = base_word;
		end
	end

endmodule

/* rtl/yuvq_merge.sv */
// Output stage: gathers the four lane words of a quad into one result
// register with its own valid/ready handshake. Uses yuvq_pkg.
module yuvq_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             lane_valid,
	output logic             lane_ready,
	input  yuvq_pkg::pixel_t lane_pixel [yuvq_pkg::LANES],
	output logic             out_valid,
	input  logic             out_ready,
	output yuvq_pkg::pixel_t out_pixel [yuvq_pkg::LANES]
);

	logic valid_s3;

	assign lane_ready = !valid_s3 || out_ready;
	assign out_valid  = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (lane_ready) begin
			valid_s3 <= lane_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (lane_ready && lane_valid) begin
			out_pixel <= lane_pixel;
		end
	end

endmodule

/* rtl/yuv420_quad_to_rgba.sv */
// YUV 4:2:0 quad to packed 32-bit pixels. One quad (four luma, shared Cb/Cr,
// four alpha-plane luma) is taken per clock unless stalled and becomes four
// packed words through the input register, the product register of each lane
// and the result register. Each stage stalls on its own, so a quad is taken
// while a finished result waits if an earlier stage is empty. Mode and alpha
// enable are set over the APB port (0x0, 0x4) and should change only when idle.
module yuv420_quad_to_rgba (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [yuvq_pkg::ADDR_W-1:0]     paddr,
	input  logic [yuvq_pkg::DATA_W-1:0]     pwdata,
	output logic [yuvq_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            quad_valid,
	output logic                            quad_ready,
	input  logic [7:0]                      luma_top_left,
	input  logic [7:0]                      luma_top_right,
	input  logic [7:0]                      luma_bottom_left,
	input  logic [7:0]                      luma_bottom_right,
	input  logic [7:0]                      chroma_blue,
	input  logic [7:0]                      chroma_red,
	input  logic [7:0]                      alpha_top_left,
	input  logic [7:0]                      alpha_top_right,
	input  logic [7:0]                      alpha_bottom_left,
	input  logic [7:0]                      alpha_bottom_right,
	output logic                            pixel_valid,
	input  logic                            pixel_ready,
	output logic [31:0]                     pixel_top_left,
	output logic [31:0]                     pixel_top_right,
	output logic [31:0]                     pixel_bottom_left,
	output logic [31:0]                     pixel_bottom_right
);

	yuvq_pkg::ctl_t    ctl_q;
	yuvq_pkg::ctl_t    ctl_s1;
	yuvq_pkg::ctl_t    ctl_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              ready_s1;
	logic              ready_s2;
	logic              merge_ready;
	logic              load_s1;
	logic              load_s2;
	logic              cfg_write;
	yuvq_pkg::sample_t luma_in  [yuvq_pkg::LANES];
	yuvq_pkg::sample_t alpha_in [yuvq_pkg::LANES];
	yuvq_pkg::sample_t luma_s1  [yuvq_pkg::LANES];
	yuvq_pkg::sample_t alpha_s1 [yuvq_pkg::LANES];
	yuvq_pkg::sample_t cb_s1;
	yuvq_pkg::sample_t cr_s1;
	yuvq_pkg::chroma_t chroma_s2;
	yuvq_pkg::pixel_t  lane_pixel [yuvq_pkg::LANES];
	yuvq_pkg::pixel_t  out_pixel  [yuvq_pkg::LANES];

	// Configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.pass_yuv_mode <= 1'b1;
			ctl_q.alpha_enable  <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[2])
				yuvq_pkg::REG_PASS_YUV_MODE: ctl_q.pass_yuv_mode <= pwdata[0];
				yuvq_pkg::REG_ALPHA_ENABLE:  ctl_q.alpha_enable  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			yuvq_pkg::REG_PASS_YUV_MODE:
				prdata = {{(yuvq_pkg::DATA_W-1){1'b0}}, ctl_q.pass_yuv_mode};
			yuvq_pkg::REG_ALPHA_ENABLE:
				prdata = {{(yuvq_pkg::DATA_W-1){1'b0}}, ctl_q.alpha_enable};
			default:
				prdata = '0;
		endcase
	end

	// Pipeline control: each stage advances when the next one can take it
	assign ready_s2   = !valid_s2 || merge_ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign quad_ready = ready_s1;
	assign load_s1    = quad_valid && ready_s1;
	assign load_s2    = valid_s1 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= quad_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign luma_in[0]  = luma_top_left;
	assign luma_in[1]  = luma_top_right;
	assign luma_in[2]  = luma_bottom_left;
	assign luma_in[3]  = luma_bottom_right;
	assign alpha_in[0] = alpha_top_left;
	assign alpha_in[1] = alpha_top_right;
	assign alpha_in[2] = alpha_bottom_left;
	assign alpha_in[3] = alpha_bottom_right;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			luma_s1  <= luma_in;
			alpha_s1 <= alpha_in;
			cb_s1    <= chroma_blue;
			cr_s1    <= chroma_red;
			ctl_s1   <= ctl_q;
		end
		if (load_s2) begin
			ctl_s2 <= ctl_s1;
		end
	end

	yuvq_chroma u_chroma (
		.clk       (clk),
		.load_s2   (load_s2),
		.cb_s1     (cb_s1),
		.cr_s1     (cr_s1),
		.chroma_s2 (chroma_s2)
	);

	for (genvar i = 0; i < yuvq_pkg::LANES; i++) begin : g_lane
		yuvq_lane u_lane (
			.clk       (clk),
			.load_s2   (load_s2),
			.luma_s1   (luma_s1[i]),
			.alpha_s1  (alpha_s1[i]),
			.chroma_s2 (chroma_s2),
			.ctl_s2    (ctl_s2),
			.pixel     (lane_pixel[i])
		);
	end

	yuvq_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_valid (valid_s2),
		.lane_ready (merge_ready),
		.lane_pixel (lane_pixel),
		.out_valid  (pixel_valid),
		.out_ready  (pixel_ready),
		.out_pixel  (out_pixel)
	);

	assign pixel_top_left     = out_pixel[0];
	assign pixel_top_right    = out_pixel[1];
	assign pixel_bottom_left  = out_pixel[2];
	assign pixel_bottom_right = out_pixel[3];

endmodule

/* rtl/yuvq_checker.sv */
// Port-level checks for yuv420_quad_to_rgba, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module yuvq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        quad_valid,
	input logic        quad_ready,
	input logic        pixel_valid,
	input logic        pixel_ready,
	input logic [31:0] pixel_top_left
);

	// An empty output stage never blocks a new quad.
	`CHK_ASSERT(a_ready_when_idle, !pixel_valid |-> quad_ready, "quad_ready low with output empty")

	// A result appearing at an empty output follows a request through the input and product registers.
	`CHK_ASSERT(a_latency, $rose(pixel_valid) |-> $past(quad_valid && quad_ready, 3), "result without a matching request")

	// A stalled result holds its top-left pixel word.
	`CHK_STALL_HOLD(a_out_hold, pixel_valid, pixel_ready, pixel_top_left, "stalled result changed")

endmodule

bind yuv420_quad_to_rgba yuvq_checker u_yuvq_checker (.*);
